FILE: sv/stepper_ramp_pulse_generator_defines.svh
// Assertion macros for the stepper ramp pulse generator.
// Needs nothing else; included by the files that carry assertions.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRPG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/srpg_pkg.sv
// Shared types, widths and constants of the stepper ramp pulse generator.
// Depends on nothing; every module of the block imports it.
package srpg_pkg;

  localparam int unsigned ANGLE_W    = 24;
  localparam int unsigned STEPS_W    = 26;
  localparam int unsigned HP_W       = 9;
  localparam int unsigned SPD_W      = 10;
  localparam int unsigned FHP_W      = 8;
  localparam int unsigned RAMP_W     = 10;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;

  localparam logic [SPD_W-1:0]  SPD_RESET  = SPD_W'(200);
  localparam logic [FHP_W-1:0]  FHP_RESET  = FHP_W'(100);
  localparam logic [RAMP_W-1:0] RAMP_RESET = RAMP_W'(50);

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEPS_PER_DEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAST_HALF     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RAMP_STEPS    = 2'd2;

  typedef struct packed {
    logic [SPD_W-1:0]  steps_per_degree;
    logic [FHP_W-1:0]  fast_half_period;
    logic [RAMP_W-1:0] ramp_steps;
  } srpg_cfg_t;

  typedef struct packed {
    logic step_pin;
    logic dir_pin;
    logic busy_res;
    logic move_ignored;
  } srpg_res_t;

endpackage

FILE: sv/srpg_cfg.sv
// Configuration register bank of the stepper ramp pulse generator.
// Depends on srpg_pkg.
module srpg_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output srpg_pkg::srpg_cfg_t                cfg_o
);
  import srpg_pkg::*;

  srpg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_STEPS_PER_DEG: cfg_d.steps_per_degree = cfg_data_i[SPD_W-1:0];
        CFG_IDX_FAST_HALF:     cfg_d.fast_half_period = cfg_data_i[FHP_W-1:0];
        CFG_IDX_RAMP_STEPS:    cfg_d.ramp_steps       = cfg_data_i[RAMP_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steps_per_degree <= SPD_RESET;
      cfg_q.fast_half_period <= FHP_RESET;
      cfg_q.ramp_steps       <= RAMP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/srpg_step_calc.sv
// Converts a target angle into direction and saturated step count.
// Depends on srpg_pkg.
module srpg_step_calc #(
  parameter int unsigned ANGLE_FRAC_BITS = srpg_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic signed [srpg_pkg::ANGLE_W-1:0] target_i,
  input  logic signed [srpg_pkg::ANGLE_W-1:0] present_i,
  input  logic [srpg_pkg::SPD_W-1:0]          steps_per_degree_i,
  output logic                                dir_o,
  output logic [srpg_pkg::STEPS_W-1:0]        steps_o
);
  import srpg_pkg::*;

  localparam int unsigned PROD_W = ANGLE_W + SPD_W;

  logic signed [ANGLE_W:0] delta;
  logic [ANGLE_W:0]        neg_delta;
  logic [ANGLE_W-1:0]      mag;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       scaled;

  // The difference of two 24-bit angles needs 25 bits; its magnitude fits 24.
  assign delta     = {target_i[ANGLE_W-1], target_i} - {present_i[ANGLE_W-1], present_i};
  assign neg_delta = ~delta + 1'b1;
  assign mag       = delta[ANGLE_W] ? neg_delta[ANGLE_W-1:0] : delta[ANGLE_W-1:0];
  assign prod      = PROD_W'(mag) * PROD_W'(steps_per_degree_i);
  assign scaled    = prod >> ANGLE_FRAC_BITS;

  assign dir_o   = ~delta[ANGLE_W];
  assign steps_o = (|scaled[PROD_W-1:STEPS_W]) ? {STEPS_W{1'b1}} : scaled[STEPS_W-1:0];

endmodule

FILE: sv/srpg_core.sv
// Move and pulse-timing state of the stepper ramp pulse generator.
// Depends on srpg_pkg; takes the step count from srpg_step_calc.
module srpg_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                cmd_i,
  input  logic signed [srpg_pkg::ANGLE_W-1:0] target_i,
  input  srpg_pkg::srpg_cfg_t                 cfg_i,
  input  logic                                calc_dir_i,
  input  logic [srpg_pkg::STEPS_W-1:0]        calc_steps_i,
  output logic signed [srpg_pkg::ANGLE_W-1:0] present_o,
  output srpg_pkg::srpg_res_t                 res_o
);
  import srpg_pkg::*;

  logic signed [ANGLE_W-1:0] present_q, present_d;
  logic [STEPS_W-1:0]        total_q, total_d;
  logic [STEPS_W-1:0]        index_q, index_d;
  logic [HP_W-1:0]           half_q, half_d;
  logic [HP_W-1:0]           tick_q, tick_d;
  logic                      phase_q, phase_d;
  logic                      dir_q, dir_d;
  logic                      moving_q, moving_d;
  logic                      ignored;

  logic [HP_W-1:0]    len;
  logic [HP_W-1:0]    tick_inc;
  logic [STEPS_W-1:0] index_inc;

  // Half period adjustment applied at the start of each step.
  function automatic logic [HP_W-1:0] ramp_adj(input logic [STEPS_W-1:0] idx,
                                               input logic [STEPS_W-1:0] total,
                                               input logic [HP_W-1:0]    hp,
                                               input srpg_cfg_t          c);
    logic [HP_W-1:0]           slow;
    logic [HP_W-1:0]           h;
    logic signed [STEPS_W:0]   lim;
    slow = {c.fast_half_period, 1'b0};
    h    = hp;
    if (idx < {{(STEPS_W-RAMP_W){1'b0}}, c.ramp_steps} && h > {1'b0, c.fast_half_period})
      h = h - 1'b1;
    lim = $signed({1'b0, total}) - $signed({{(STEPS_W+1-RAMP_W){1'b0}}, c.ramp_steps});
    if ($signed({1'b0, idx}) > lim && h < slow)
      h = h + 1'b1;
    return h;
  endfunction

  assign len       = (half_q == '0) ? HP_W'(1) : half_q;
  assign tick_inc  = tick_q + 1'b1;
  assign index_inc = index_q + 1'b1;

  always_comb begin
    present_d = present_q;
    total_d   = total_q;
    index_d   = index_q;
    half_d    = half_q;
    tick_d    = tick_q;
    phase_d   = phase_q;
    dir_d     = dir_q;
    moving_d  = moving_q;
    ignored   = 1'b0;
    if (cmd_i == CMD_MOVE) begin
      if (moving_q) begin
        ignored = 1'b1;
      end else begin
        dir_d     = calc_dir_i;
        total_d   = calc_steps_i;
        present_d = target_i;
        index_d   = '0;
        tick_d    = '0;
        half_d    = {cfg_i.fast_half_period, 1'b0};
        if (calc_steps_i != '0) begin
          half_d   = ramp_adj('0, calc_steps_i, {cfg_i.fast_half_period, 1'b0}, cfg_i);
          phase_d  = 1'b1;
          moving_d = 1'b1;
        end else begin
          phase_d = 1'b0;
        end
      end
    end else if (moving_q) begin
      tick_d = tick_inc;
      if (tick_inc >= len) begin
        tick_d = '0;
        if (phase_q) begin
          phase_d = 1'b0;
        end else begin
          index_d = index_inc;
          if (index_inc >= total_q) begin
            moving_d = 1'b0;
          end else begin
            half_d  = ramp_adj(index_inc, total_q, half_q, cfg_i);
            phase_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      total_q   <= '0;
      index_q   <= '0;
      half_q    <= '0;
      tick_q    <= '0;
      phase_q   <= 1'b0;
      dir_q     <= 1'b0;
      moving_q  <= 1'b0;
    end else if (accept_i) begin
      present_q <= present_d;
      total_q   <= total_d;
      index_q   <= index_d;
      half_q    <= half_d;
      tick_q    <= tick_d;
      phase_q   <= phase_d;
      dir_q     <= dir_d;
      moving_q  <= moving_d;
    end
  end

  assign present_o          = present_q;
  assign res_o.step_pin     = phase_d;
  assign res_o.dir_pin      = dir_d;
  assign res_o.busy_res     = moving_d;
  assign res_o.move_ignored = ignored;

endmodule

FILE: sv/srpg_out_reg.sv
// Result register of the stepper ramp pulse generator with valid/stall control.
// Depends on srpg_pkg.
module srpg_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  srpg_pkg::srpg_res_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                full_stall_o,
  output srpg_pkg::srpg_res_t res_o
);
  import srpg_pkg::*;

  logic      valid_q, valid_d;
  srpg_res_t res_q;

  // Upstream may transfer whenever the held result leaves or there is none.
  assign full_stall_o = valid_q & out_stall_i;
  assign valid_d      = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: sv/stepper_ramp_pulse_generator.sv
// Stepper ramp pulse generator: one registered result per item. Throughput is
// one item per cycle unless stalled; the core state and the result register
// both update at the input transfer, and a new item is taken while the output
// register drains. Reset (rst_ni low, asynchronous) clears all motion state,
// empties the result register and loads the register defaults 200, 100, 50.
`include "stepper_ramp_pulse_generator_defines.svh"

module stepper_ramp_pulse_generator #(
  parameter int unsigned ANGLE_FRAC_BITS = srpg_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [srpg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [srpg_pkg::ANGLE_W-1:0] target_angle_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                step_pin_o,
  output logic                                dir_pin_o,
  output logic                                busy_res_o,
  output logic                                move_ignored_o
);
  import srpg_pkg::*;

  srpg_cfg_t                 cfg;
  srpg_res_t                 res_next;
  srpg_res_t                 res_held;
  logic signed [ANGLE_W-1:0] present;
  logic                      calc_dir;
  logic [STEPS_W-1:0]        calc_steps;
  logic                      in_xfer;

  // An input transfer happens whenever the result register can take the
  // result in the same edge, so the core and the output always move together.
  assign in_xfer = in_valid_i & ~in_stall_o;

  srpg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Angle difference, magnitude and step count for a move request; the
  // single 24 by 10 bit multiply sits here.
  srpg_step_calc #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_step_calc (
    .target_i           (target_angle_i),
    .present_i          (present),
    .steps_per_degree_i (cfg.steps_per_degree),
    .dir_o              (calc_dir),
    .steps_o            (calc_steps)
  );

  // The core holds the present angle, step counters, half period and pulse
  // phase. Its result is the state after the update of the transferred item.
  srpg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_xfer),
    .cmd_i        (cmd_i),
    .target_i     (target_angle_i),
    .cfg_i        (cfg),
    .calc_dir_i   (calc_dir),
    .calc_steps_i (calc_steps),
    .present_o    (present),
    .res_o        (res_next)
  );

  srpg_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_xfer),
    .res_i        (res_next),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .full_stall_o (in_stall_o),
    .res_o        (res_held)
  );

  assign step_pin_o     = res_held.step_pin;
  assign dir_pin_o      = res_held.dir_pin;
  assign busy_res_o     = res_held.busy_res;
  assign move_ignored_o = res_held.move_ignored;

  // A dropped move can only be reported while a move is running.
  `SRPG_ASSERT_NOW(a_ignored_busy, clk_i, rst_ni, out_valid_o && move_ignored_o, busy_res_o, "move dropped while idle")
  // The step pin is never high outside a move.
  `SRPG_ASSERT_NOW(a_step_busy, clk_i, rst_ni, out_valid_o && step_pin_o, busy_res_o, "step pin high while idle")
  // The input is held off only by a full, stalled result register.
  `SRPG_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with empty output")
  // Every input transfer leaves a result waiting in the next cycle.
  `SRPG_ASSERT_NEXT(a_xfer_result, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o, "transfer lost its result")

endmodule
